>>> hdl/csvt_pkg.sv
// Package for the CSV line field tokenizer.
// Holds the parse mode type, character constants and the step result struct.
// No dependencies.
`default_nettype none

package csvt_pkg;

    localparam int MAX_FIELDS_DEF = 64;
    localparam int FIELD_NUM_W    = 6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3,
        MODE_SKIP   = 3'd4
    } mode_t;

    typedef struct packed {
        logic  emit;
        logic  done;
        mode_t mode_next;
    } step_t;

endpackage

`default_nettype wire

>>> hdl/csvt_step.sv
// Per-byte parse step of the CSV line field tokenizer.
// Combinational next mode, emit and field-end decisions; uses csvt_pkg.
`default_nettype none

module csvt_step
    import csvt_pkg::*;
(
    input  wire mode_t       mode,
    input  wire logic [7:0]  char_in,
    input  wire logic        line_last,
    input  wire logic        limit_hit,
    output step_t            step
);

    logic  is_quote;
    logic  is_comma;
    logic  is_blank;
    mode_t mode_next;
    logic  emit;
    logic  done_base;
    logic  done_end;

    assign is_quote = (char_in == CH_QUOTE);
    assign is_comma = (char_in == CH_COMMA);
    assign is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB);

    always_comb
    begin
        unique case (mode)
            MODE_PLAIN:  mode_next = is_comma ? MODE_START : MODE_PLAIN;
            MODE_QUOTED: mode_next = is_quote ? MODE_QSEEN : MODE_QUOTED;
            MODE_QSEEN:
            begin
                if (is_quote)
                    mode_next = MODE_QUOTED;
                else if (is_comma)
                    mode_next = MODE_START;
                else
                    mode_next = MODE_SKIP;
            end
            MODE_SKIP:   mode_next = is_comma ? MODE_START : MODE_SKIP;
            default:
            begin
                if (limit_hit || is_blank || is_comma)
                    mode_next = MODE_START;
                else if (is_quote)
                    mode_next = MODE_QUOTED;
                else
                    mode_next = MODE_PLAIN;
            end
        endcase
    end

    always_comb
    begin
        unique case (mode)
            MODE_PLAIN:
            begin
                emit      = !is_comma;
                done_base = is_comma;
            end
            MODE_QUOTED:
            begin
                emit      = !is_quote;
                done_base = 1'b0;
            end
            MODE_QSEEN:
            begin
                emit      = is_quote;
                done_base = !is_quote;
            end
            MODE_SKIP:
            begin
                emit      = 1'b0;
                done_base = 1'b0;
            end
            default:
            begin
                emit      = !limit_hit && !is_blank && !is_quote && !is_comma;
                done_base = !limit_hit && is_comma;
            end
        endcase
    end

    // At line end an open field closes, and so does a field of blanks only.
    always_comb
    begin
        done_end = 1'b0;
        if (line_last)
        begin
            if (mode_next == MODE_PLAIN || mode_next == MODE_QUOTED ||
                mode_next == MODE_QSEEN)
                done_end = 1'b1;
            else if (mode_next == MODE_START && !limit_hit && is_blank)
                done_end = 1'b1;
        end
    end

    assign step.emit      = emit;
    assign step.done      = done_base || done_end;
    assign step.mode_next = mode_next;

endmodule

`default_nettype wire

>>> hdl/csv_line_field_tokenizer.sv
// Top level of the CSV line field tokenizer: input register, parse state and result register.
// Depends on csvt_pkg and csvt_step.
`default_nettype none

// Takes one byte of a text line per transaction and returns at most one result transaction
// per byte: a content byte, a field end, a line end, or a combination. Bytes that only skip
// blanks or discard text after a closing quote give no result unless they end the line.
// One byte is accepted every cycle when the output side keeps up; each byte passes from the
// input register to the result register, where its result appears. The rate is set by the parse
// mode and field count registers, which are updated as each byte leaves the input register.
// Fields past MAX_FIELDS are dropped; the line end is still reported.
module csv_line_field_tokenizer
    import csvt_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_in,
    input  wire logic                   line_last,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  char_out,
    output logic                        has_char,
    output logic                        field_done,
    output logic [FIELD_NUM_W-1:0]      field_number,
    output logic                        line_done
);

    localparam int CNT_W = $clog2(MAX_FIELDS + 1);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [7:0]             s1_char_reg;
    logic                   s1_last_reg;
    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [CNT_W-1:0]       fields_reg;
    logic [CNT_W-1:0]       fields_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             char_out_reg;
    logic                   has_char_reg;
    logic                   field_done_reg;
    logic [FIELD_NUM_W-1:0] field_number_reg;
    logic                   line_done_reg;

    logic                   limit_hit;
    step_t                  step;
    logic                   has_result;
    logic                   advance;
    logic                   s1_retire;

    assign limit_hit = (fields_reg >= CNT_W'(MAX_FIELDS));

    csvt_step u_step (
        .mode      (mode_reg),
        .char_in   (s1_char_reg),
        .line_last (s1_last_reg),
        .limit_hit (limit_hit),
        .step      (step)
    );

    assign has_result = step.emit || step.done || s1_last_reg;
    assign advance    = !out_valid_reg || !out_stall;
    assign s1_retire  = s1_valid_reg && (!has_result || advance);
    assign in_stall   = s1_valid_reg && !s1_retire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
            s1_valid_next = in_valid;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        fields_next = fields_reg;
        if (s1_retire)
        begin
            if (s1_last_reg)
            begin
                mode_next   = MODE_START;
                fields_next = '0;
            end
            else
            begin
                mode_next = step.mode_next;
                if (step.done)
                    fields_next = fields_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s1_retire && has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            mode_reg      <= MODE_START;
            fields_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            mode_reg      <= mode_next;
            fields_reg    <= fields_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= line_last;
        end
        if (advance && s1_retire && has_result)
        begin
            char_out_reg     <= step.emit ? s1_char_reg : 8'd0;
            has_char_reg     <= step.emit;
            field_done_reg   <= step.done;
            field_number_reg <= (step.emit || step.done) ?
                                FIELD_NUM_W'(fields_reg) : '0;
            line_done_reg    <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_out     = char_out_reg;
    assign has_char     = has_char_reg;
    assign field_done   = field_done_reg;
    assign field_number = field_number_reg;
    assign line_done    = line_done_reg;

`ifndef SYNTH
    a_fields_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fields_reg) <= MAX_FIELDS)
        else $error("Field count exceeds the field limit.");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_retire && s1_last_reg |=> mode_reg == MODE_START && fields_reg == '0)
        else $error("Parse state not cleared after a line end.");

    a_field_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (has_char || field_done) |-> int'(field_number) < MAX_FIELDS)
        else $error("Result carries a field index beyond the limit.");

    a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> char_out == 8'd0)
        else $error("Result without content carries a nonzero byte.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && s1_valid_reg && has_result |-> in_stall)
        else $error("Input taken while a pending result has nowhere to go.");
`endif

endmodule

`default_nettype wire
